@@ sv/sip_pkg.sv @@
// ----------------------------------------------------------------------------
// sip_pkg: shared constants for the segment intersection pipeline
// widths of the input and output transactions
// ----------------------------------------------------------------------------
package sip_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int OUT_USER_BITS  = 1;
endpackage

@@ sv/sip_divider.sv @@
// ----------------------------------------------------------------------------
// sip_divider: pipelined restoring divider
// one quotient bit per stage, unsigned, with a side payload
// ----------------------------------------------------------------------------
module sip_divider
    import sip_pkg::*;
#(
    parameter int NUM_BITS = 34,
    parameter int DEN_BITS = 34,
    parameter int Q_BITS   = 17,
    parameter int SIDE_BITS = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [NUM_BITS-1:0]  i_num,
    input  logic [DEN_BITS-1:0]  i_den,
    input  logic [SIDE_BITS-1:0] i_side,
    output logic                 o_valid,
    output logic [Q_BITS-1:0]    o_quo,
    output logic [SIDE_BITS-1:0] o_side
);
    // quotient is known to fit Q_BITS, so only Q_BITS steps are needed:
    // the remainder starts as num >> Q_BITS which is below den
    localparam int RB = DEN_BITS + 1;

    logic [RB-1:0]        r_rem  [Q_BITS];
    logic [NUM_BITS-1:0]  r_num  [Q_BITS];
    logic [DEN_BITS-1:0]  r_den  [Q_BITS];
    logic [Q_BITS-1:0]    r_quo  [Q_BITS];
    logic [SIDE_BITS-1:0] r_side [Q_BITS];
    logic [Q_BITS-1:0]    r_vld;

    for (genvar s = 0; s < Q_BITS; s++) begin : g_step
        logic [RB-1:0]        n_rem;
        logic [NUM_BITS-1:0]  n_num;
        logic [DEN_BITS-1:0]  n_den;
        logic [Q_BITS-1:0]    n_quo;
        logic [SIDE_BITS-1:0] n_side;
        logic                 n_vld;
        logic [RB-1:0]        n_trial;
        logic [RB:0]          n_diff;
        if (s == 0) begin : g_first
            assign n_rem  = RB'(i_num >> Q_BITS);
            assign n_num  = i_num;
            assign n_den  = i_den;
            assign n_quo  = '0;
            assign n_side = i_side;
            assign n_vld  = i_valid;
        end else begin : g_next
            assign n_rem  = r_rem[s-1];
            assign n_num  = r_num[s-1];
            assign n_den  = r_den[s-1];
            assign n_quo  = r_quo[s-1];
            assign n_side = r_side[s-1];
            assign n_vld  = r_vld[s-1];
        end
        assign n_trial = {n_rem[RB-2:0], n_num[Q_BITS-1-s]};
        assign n_diff  = {1'b0, n_trial} - {2'b0, n_den};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= n_vld;
            end
            if (i_en) begin
                r_rem[s]  <= n_diff[RB] ? n_trial : n_diff[RB-1:0];
                r_quo[s]  <= {n_quo[Q_BITS-2:0], ~n_diff[RB]};
                r_num[s]  <= n_num;
                r_den[s]  <= n_den;
                r_side[s] <= n_side;
            end
        end
    end

    assign o_valid = r_vld[Q_BITS-1];
    assign o_quo   = r_quo[Q_BITS-1];
    assign o_side  = r_side[Q_BITS-1];
endmodule

@@ sv/segment_intersection_point.sv @@
// ----------------------------------------------------------------------------
// segment_intersection_point: exact 2-D segment crossing test and point
// ----------------------------------------------------------------------------
// usage:
//  s_axis carries one segment pair per transaction, eight signed coordinates
//  packed in tdata. m_axis returns one transaction per pair: tuser is the hit
//  flag, tdata the crossing point (zero when there is no hit).
//  from input to output register the pipeline has four front stages,
//  COORD_BITS + 1 divider stages and the output register.
//  throughput: one pair per cycle unless m_axis_tready stalls; one stage per
//  quotient bit in each of two divider chains (x and y share den and side data).
//  the whole pipeline advances only when the output register is free or being
//  taken, so a stall of m_axis_tready holds every stage; nothing is dropped.
//  s_axis_tready is high whenever the pipeline can advance.
//  reset clears all valid bits; payload registers are not reset.
//  stage 1: differences; stage 2: products; stage 3: den, numerators,
//  sign folding; stage 4: hit test and dir*n1 products; then dividers.
// ----------------------------------------------------------------------------
module segment_intersection_point
    import sip_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  logic [((8*COORD_BITS+7)/8)*8-1:0]   s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // cross_x, cross_y
    output logic [((2*COORD_BITS+7)/8)*8-1:0]   m_axis_tdata,
    // hit
    output logic [OUT_USER_BITS-1:0]            m_axis_tuser
);
    localparam int CB = COORD_BITS;
    localparam int DB = CB + 1;        // differences
    localparam int PB = 2 * DB;        // products
    localparam int SB = PB + 1;        // den, numerators
    localparam int MB = SB;            // magnitudes after folding
    localparam int NB = DB + MB;       // dir*n1 product
    localparam int QB = DB;            // offset quotient, |off| <= |dir|
    localparam int OB = ((2*CB+7)/8)*8;

    logic n_en;
    assign n_en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = n_en;

    // stage 1: differences
    logic signed [CB-1:0] n_c [8];
    for (genvar k = 0; k < 8; k++) begin : g_in
        assign n_c[k] = s_axis_tdata[k*CB +: CB];
    end
    logic                 r_v1;
    logic signed [DB-1:0] r_dx12, r_dy12, r_dx34, r_dy34, r_abx, r_bay;
    logic signed [CB-1:0] r1_ax, r1_ay;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (n_en) r_v1 <= s_axis_tvalid;
        if (n_en) begin
            r_dx12 <= DB'(n_c[2]) - DB'(n_c[0]);
            r_dy12 <= DB'(n_c[3]) - DB'(n_c[1]);
            r_dx34 <= DB'(n_c[6]) - DB'(n_c[4]);
            r_dy34 <= DB'(n_c[7]) - DB'(n_c[5]);
            r_abx  <= DB'(n_c[0]) - DB'(n_c[4]);
            r_bay  <= DB'(n_c[5]) - DB'(n_c[1]);
            r1_ax  <= n_c[0];
            r1_ay  <= n_c[1];
        end
    end

    // stage 2: six products (n2 = abx*dy12 + bay*dx12, so no sign change is needed)
    logic                 r_v2;
    logic signed [PB-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [DB-1:0] r2_dx, r2_dy;
    logic signed [CB-1:0] r2_ax, r2_ay;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (n_en) r_v2 <= r_v1;
        if (n_en) begin
            r_p0 <= r_dy12 * r_dx34;
            r_p1 <= r_dx12 * r_dy34;
            r_p2 <= r_abx * r_dy34;
            r_p3 <= r_bay * r_dx34;
            r_p4 <= r_abx * r_dy12;
            r_p5 <= r_bay * r_dx12;
            r2_dx <= r_dx12;
            r2_dy <= r_dy12;
            r2_ax <= r1_ax;
            r2_ay <= r1_ay;
        end
    end

    // stage 3: den, n1, m2 with the sign of den folded in
    logic signed [SB-1:0] n_den, n_n1, n_m2;
    assign n_den = SB'(r_p0) - SB'(r_p1);
    assign n_n1  = SB'(r_p2) + SB'(r_p3);
    assign n_m2  = SB'(r_p4) + SB'(r_p5);  // m2 = this sum, since -(-abx..)
    logic                 r_v3;
    logic signed [SB-1:0] r_den, r_n1, r_m2;
    logic signed [DB-1:0] r3_dx, r3_dy;
    logic signed [CB-1:0] r3_ax, r3_ay;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (n_en) r_v3 <= r_v2;
        if (n_en) begin
            r_den <= n_den[SB-1] ? -n_den : n_den;
            r_n1  <= n_den[SB-1] ? -n_n1  : n_n1;
            r_m2  <= n_den[SB-1] ? -n_m2  : n_m2;
            r3_dx <= r2_dx;
            r3_dy <= r2_dy;
            r3_ax <= r2_ax;
            r3_ay <= r2_ay;
        end
    end

    // stage 4: hit test and |dir|*n1
    logic n_hit;
    assign n_hit = (r_den != '0) && !r_n1[SB-1] && !r_m2[SB-1]
                   && (r_den >= r_n1) && (r_den >= r_m2);
    logic [DB-1:0] n_mdx, n_mdy;
    assign n_mdx = r3_dx[DB-1] ? DB'(-r3_dx) : DB'(r3_dx);
    assign n_mdy = r3_dy[DB-1] ? DB'(-r3_dy) : DB'(r3_dy);
    logic          r_v4, r4_hit;
    logic [NB-1:0] r_nx, r_ny;
    logic [MB-1:0] r4_den;
    localparam int SIDEB = 1 + 2 + 2*CB;  // hit, dir signs, starts
    logic [SIDEB-1:0] r4_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else if (n_en) r_v4 <= r_v3;
        if (n_en) begin
            r_nx   <= NB'(n_mdx) * NB'(r_n1);
            r_ny   <= NB'(n_mdy) * NB'(r_n1);
            r4_den <= n_hit ? MB'(r_den) : MB'(1);
            r4_side <= {n_hit, r3_dx[DB-1], r3_dy[DB-1], r3_ay, r3_ax};
            r4_hit <= n_hit;
        end
    end

    // dividers: offset = |dir|*n1/den < 2^DB when hit (n1 <= den)
    logic             n_xv, n_yv;
    logic [QB-1:0]    n_qx, n_qy;
    logic [SIDEB-1:0] n_side, n_side_y;
    logic [NB-1:0]    n_numx, n_numy;
    assign n_numx = r4_hit ? r_nx : '0;
    assign n_numy = r4_hit ? r_ny : '0;
    sip_divider #(.NUM_BITS(NB), .DEN_BITS(MB), .Q_BITS(QB), .SIDE_BITS(SIDEB)) u_div_x (
        .i_clk, .i_rst_n, .i_en(n_en), .i_valid(r_v4), .i_num(n_numx),
        .i_den(r4_den), .i_side(r4_side), .o_valid(n_xv), .o_quo(n_qx), .o_side(n_side)
    );
    sip_divider #(.NUM_BITS(NB), .DEN_BITS(MB), .Q_BITS(QB), .SIDE_BITS(SIDEB)) u_div_y (
        .i_clk, .i_rst_n, .i_en(n_en), .i_valid(r_v4), .i_num(n_numy),
        .i_den(r4_den), .i_side(r4_side), .o_valid(n_yv), .o_quo(n_qy),
        .o_side(n_side_y)
    );

    // final stage: apply offsets, output register
    logic          n_fhit, n_sx, n_sy;
    logic [CB-1:0] n_ax, n_ay, n_px, n_py;
    assign {n_fhit, n_sx, n_sy, n_ay, n_ax} = n_side;
    assign n_px = n_sx ? n_ax - CB'(n_qx) : n_ax + CB'(n_qx);
    assign n_py = n_sy ? n_ay - CB'(n_qy) : n_ay + CB'(n_qy);

    logic          r_ov, r_ohit;
    logic [CB-1:0] r_ox, r_oy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (n_en) r_ov <= n_xv;
        if (n_en) begin
            r_ohit <= n_fhit;
            r_ox   <= n_fhit ? n_px : '0;
            r_oy   <= n_fhit ? n_py : '0;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = OUT_USER_BITS'(r_ohit);
    assign m_axis_tdata  = OB'({r_oy, r_ox});

    // checks
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_xv == n_yv) else $error("divider lanes out of step");
    a_side_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_xv |-> n_side == n_side_y) else $error("divider side data differs");
    a_zero_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_ohit) |-> (r_ox == '0 && r_oy == '0))
        else $error("point not zero on miss");
    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !m_axis_tready) |=> (r_ov && $stable(r_ox) && $stable(r_oy)))
        else $error("output changed under stall");
endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for segment_intersection_point
// drives segment pairs over the input stream with random gaps and stalls,
// predicts hit flag and crossing point exactly, and checks every output
// transaction in order against the predicted ones
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import sip_pkg::*;

    localparam int CB        = COORD_BITS_DEF;
    localparam int LATENCY   = CB + 6;
    localparam int NUM_RAND  = 1730;
    localparam int MAX_CYCLE = 400000;

    typedef struct packed {
        logic signed [CB-1:0] by2, bx2, by1, bx1, ay2, ax2, ay1, ax1;
    } seg_pair_t;

    typedef struct {
        logic          hit;
        logic [CB-1:0] px;
        logic [CB-1:0] py;
    } crossing_t;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    logic [((8*CB+7)/8)*8-1:0]           s_axis_tdata;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready;
    logic [((2*CB+7)/8)*8-1:0]           m_axis_tdata;
    logic [OUT_USER_BITS-1:0]            m_axis_tuser;

    seg_pair_t pair_queue[$];
    crossing_t crossing_queue[$];
    int        error_count;
    int        cycle_count;
    int        pairs_sent;
    int        crossings_seen;
    int        hits_seen;
    bit        steady_phase;    // no idling on either side
    bit        drain_request;   // sender holds until everything has come back
    int        hold_cycles;     // receiver long hold-off, counted down
    bit        stim_done;
    bit        in_fire;         // input transaction taken at the last rising edge

    segment_intersection_point #(.COORD_BITS(CB)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // exact crossing prediction; all products fit comfortably in 80 bits
    function automatic crossing_t predict_crossing(seg_pair_t p);
        logic signed [79:0] ax, ay, dxa, dya, dxb, dyb, den, n1, n2, qx, qy;
        crossing_t r;
        ax  = p.ax1;
        ay  = p.ay1;
        dxa = p.ax2 - ax;
        dya = p.ay2 - ay;
        dxb = p.bx2 - p.bx1;
        dyb = p.by2 - p.by1;
        den = dya * dxb - dxa * dyb;
        n1  = (ax - p.bx1) * dyb + (p.by1 - ay) * dxb;
        n2  = -((p.bx1 - ax) * dya + (ay - p.by1) * dxa);
        r.hit = 1'b0;
        r.px  = '0;
        r.py  = '0;
        if (den != 0) begin
            if (den < 0) begin
                den = -den;
                n1  = -n1;
                n2  = -n2;
            end
            if (n1 >= 0 && n1 <= den && n2 >= 0 && n2 <= den) begin
                // signed division truncates toward zero, as the block does
                qx = (dxa * n1) / den;
                qy = (dya * n1) / den;
                r.hit = 1'b1;
                r.px  = CB'(ax + qx);
                r.py  = CB'(ay + qy);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [CB-1:0] got, logic [CB-1:0] want);
        $display("mismatch %s: got %h expected %h (result %0d)", what, got, want,
                 crossings_seen);
        error_count++;
    endtask

    function automatic logic signed [CB-1:0] rand_coord();
        logic signed [CB-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = {1'b1, {(CB-1){1'b0}}};
            1:       v = {1'b0, {(CB-1){1'b1}}};
            2, 3:    v = CB'($signed($urandom_range(0, 200)) - 100);
            default: v = CB'($urandom);
        endcase
        return v;
    endfunction

    // build random pairs, often around a point: two segments spanning it in x and in y
    function automatic seg_pair_t rand_pair();
        seg_pair_t p;
        int sel;
        int cx, cy, r;
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
            r  = (sel < 20) ? 16000 : 400;
            cx = $signed($urandom_range(0, 2 * r)) - r;
            cy = $signed($urandom_range(0, 2 * r)) - r;
            p.ax1 = CB'(cx - $signed($urandom_range(0, r)));
            p.ay1 = CB'(cy - $signed($urandom_range(0, 2 * r)) + r);
            p.ax2 = CB'(cx + $signed($urandom_range(0, r)));
            p.ay2 = CB'(cy + $signed($urandom_range(0, 2 * r)) - r);
            p.bx1 = CB'(cx - $signed($urandom_range(0, 2 * r)) + r);
            p.by1 = CB'(cy - $signed($urandom_range(0, r)));
            p.bx2 = CB'(cx + $signed($urandom_range(0, 2 * r)) - r);
            p.by2 = CB'(cy + $signed($urandom_range(0, r)));
        end else if (sel < 65) begin
            // parallel copies of a random direction, sometimes collinear
            p.ax1 = rand_coord();
            p.ay1 = rand_coord();
            p.ax2 = p.ax1 + CB'($signed($urandom_range(0, 60)) - 30);
            p.ay2 = p.ay1 + CB'($signed($urandom_range(0, 60)) - 30);
            p.bx1 = ($urandom_range(0, 1)) ? p.ax2 : rand_coord();
            p.by1 = p.ay2;
            p.bx2 = p.bx1 + (p.ax2 - p.ax1);
            p.by2 = p.by1 + (p.ay2 - p.ay1);
        end else if (sel < 70) begin
            // endpoint touching: b starts on a's end
            p = seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
            p.bx1 = p.ax2;
            p.by1 = p.ay2;
        end else begin
            p.ax1 = rand_coord(); p.ay1 = rand_coord();
            p.ax2 = rand_coord(); p.ay2 = rand_coord();
            p.bx1 = rand_coord(); p.by1 = rand_coord();
            p.bx2 = rand_coord(); p.by2 = rand_coord();
        end
        return p;
    endfunction

    function automatic seg_pair_t mk(int a, int b, int c, int d, int e, int f, int g, int h);
        seg_pair_t p;
        p.ax1 = CB'(a); p.ay1 = CB'(b); p.ax2 = CB'(c); p.ay2 = CB'(d);
        p.bx1 = CB'(e); p.by1 = CB'(f); p.bx2 = CB'(g); p.by2 = CB'(h);
        return p;
    endfunction

    // input acceptance, sampled at the rising edge
    always @(posedge i_clk) begin
        in_fire = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_fire) begin
            pairs_sent++;
        end
    end

    // driver: inputs change on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && !in_fire) begin
                // keep offering the same transaction
            end else if (pair_queue.size() != 0 && !drain_request
                         && (steady_phase || $urandom_range(0, 99) >= 27)) begin
                crossing_queue.push_back(predict_crossing(pair_queue[0]));
                s_axis_tdata  <= pair_queue.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: ready changes on the falling edge, long hold-off counted here
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= steady_phase || ($urandom_range(0, 99) >= 27);
            end
        end
    end

    // monitor: outputs sampled at the rising edge
    always @(posedge i_clk) begin
        crossing_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (crossing_queue.size() == 0) begin
                $display("unexpected output transaction");
                error_count++;
            end else begin
                want = crossing_queue.pop_front();
                if (m_axis_tuser[0] !== want.hit)
                    report_mismatch("hit", CB'(m_axis_tuser[0]), CB'(want.hit));
                if (m_axis_tdata[CB-1:0] !== want.px)
                    report_mismatch("cross_x", m_axis_tdata[CB-1:0], want.px);
                if (m_axis_tdata[2*CB-1:CB] !== want.py)
                    report_mismatch("cross_y", m_axis_tdata[2*CB-1:CB], want.py);
                hits_seen += want.hit;
            end
            crossings_seen++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLE) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL segment_intersection_point");
            $finish;
        end
    end

    initial begin
        int lo, hi;
        error_count    = 0;
        cycle_count    = 0;
        pairs_sent     = 0;
        crossings_seen = 0;
        hits_seen      = 0;
        steady_phase   = 1'b0;
        drain_request  = 1'b0;
        hold_cycles    = 0;
        stim_done      = 1'b0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        lo = -(1 << (CB - 1));
        hi = (1 << (CB - 1)) - 1;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: plain cross, endpoint touches, parallel, collinear, degenerate,
        // extremes of the coordinate range
        pair_queue.push_back(mk(-16, -16, 16, 16, -16, 16, 16, -16));
        pair_queue.push_back(mk(0, 0, 160, 0, 160, 0, 160, 80));
        pair_queue.push_back(mk(0, 0, 160, 0, 0, 0, 0, 80));
        pair_queue.push_back(mk(0, 0, 160, 0, 80, 0, 80, 80));
        pair_queue.push_back(mk(0, 0, 160, 0, 0, 16, 160, 16));
        pair_queue.push_back(mk(0, 0, 160, 0, 80, 0, 240, 0));
        pair_queue.push_back(mk(5, 5, 5, 5, 0, 0, 10, 10));
        pair_queue.push_back(mk(0, 0, 10, 10, 3, 3, 3, 3));
        pair_queue.push_back(mk(0, 0, 160, 0, 80, 1, 80, 80));
        pair_queue.push_back(mk(lo, lo, hi, hi, lo, hi, hi, lo));
        pair_queue.push_back(mk(hi, lo, lo, hi, lo, lo, hi, hi));
        pair_queue.push_back(mk(lo, 0, hi, 0, 0, lo, 0, hi));
        pair_queue.push_back(mk(lo, lo, lo, hi, lo, 0, hi, 0));
        pair_queue.push_back(mk(hi, hi, hi, hi, hi, hi, hi, hi));
        pair_queue.push_back(mk(lo, lo, lo, lo, lo, lo, lo, lo));
        pair_queue.push_back(mk(-1, -1, 0, 0, 0, -1, -1, 0));
        pair_queue.push_back(mk(0, 0, 7, 3, 0, 3, 7, 0));
        pair_queue.push_back(mk(-7, 3, 0, 0, -7, 0, 0, 3));
        pair_queue.push_back(mk(hi, 0, lo, 1, 0, lo, 1, hi));
        pair_queue.push_back(mk(-21845, 21845, 21845, -21845, -1, -1, 1, 1));

        for (int i = 0; i < NUM_RAND; i++) pair_queue.push_back(rand_pair());

        // long receiver hold-off while the sender keeps pushing
        wait (pairs_sent >= 200);
        @(negedge i_clk);
        hold_cycles = 3 * LATENCY + 50;
        // sender pause until every predicted result is back
        wait (pairs_sent >= 700);
        @(negedge i_clk);
        drain_request = 1'b1;
        wait (crossing_queue.size() == 0 && !s_axis_tvalid);
        @(negedge i_clk);
        drain_request = 1'b0;
        // stretch without idling on either side
        wait (pairs_sent >= 900);
        steady_phase = 1'b1;
        wait (pairs_sent >= 1200);
        steady_phase = 1'b0;

        wait (pair_queue.size() == 0 && !s_axis_tvalid);
        wait (crossing_queue.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("covered %0d segment pairs, %0d crossings returned, %0d of them hits",
                 pairs_sent, crossings_seen, hits_seen);
        $display("directed extremes, parallel, degenerate and endpoint cases included");
        if (error_count == 0) begin
            $display("PASS segment_intersection_point");
        end else begin
            $display("FAIL segment_intersection_point");
        end
        $finish;
    end
endmodule

@@ files.f @@
sv/sip_pkg.sv
sv/sip_divider.sv
sv/segment_intersection_point.sv
bench/tb.sv
